[rtl/bmhq_pkg.sv]
// ----------------------------------------------------------------------------
// Ready-queue min-heap package
// Shared sizes, codes, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bmhq_pkg;

   localparam int CAPACITY   = 64;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int CHILD_W    = ADDR_W + 2;
   localparam int KEY_W      = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic ACT_ENQUEUE = 1'b0;
   localparam logic ACT_DEQUEUE = 1'b1;

   localparam logic [1:0] RSP_ENQUEUED = 2'd0;
   localparam logic [1:0] RSP_DROPPED  = 2'd1;
   localparam logic [1:0] RSP_DEQUEUED = 2'd2;
   localparam logic [1:0] RSP_EMPTY    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY_MODE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_QUANTUM = CSR_IDX_W'(1);

   typedef struct packed {
      logic [15:0] tag;
      logic [7:0]  prio;
      logic [15:0] burst;
   } entry_type;

   typedef struct packed {
      logic        action;
      logic [15:0] entry_tag;
      logic [7:0]  entry_priority;
      logic [15:0] entry_burst;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_tag;
      logic [7:0]  out_priority;
      logic [15:0] out_burst;
      logic [15:0] out_quantum;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_CHECK,
      S_UP_CMP,
      S_DN_LOAD,
      S_DN_RD,
      S_DN_CMP,
      S_POST
   } fsm_state_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_PARENT,
      RD_ROOT_LAST,
      RD_CHILDREN
   } rd_kind_type;

   typedef struct packed {
      logic        load_in;    // take request entry into the moving register
      logic        up_move;    // write parent down into hole, climb
      logic        write_cur;  // settle moving entry into hole
      logic        count_inc;
      logic        dn_load;    // stage root as result, last entry becomes mover
      logic        dn_move;    // write smaller child up into hole, descend
      rd_kind_type rd_kind;
      logic        res_set;
      logic [1:0]  res_code;
      logic        post;       // stage -> output register
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic one_left;
      logic at_root;
      logic up_less;
      logic dn_stop;
      logic rsp_busy;
   } status_type;

   function automatic logic [KEY_W-1:0] key_of(entry_type e, logic mode);
      return mode ? KEY_W'(e.prio) : KEY_W'(e.burst);
   endfunction

endpackage

[rtl/bmhq_ctrl.sv]
// ----------------------------------------------------------------------------
// Ready-queue min-heap controller
// Sequences enqueue sift-up and dequeue sift-down over the heap datapath.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_ready,
   input  bmhq_pkg::status_type status,
   output bmhq_pkg::cmd_type    cmd
);
   import bmhq_pkg::*;

   fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_action == ACT_ENQUEUE) begin
                  state_in = status.full ? S_POST : S_UP_CHECK;
               end else begin
                  state_in = status.empty ? S_POST : S_DN_LOAD;
               end
            end
         end
         S_UP_CHECK: begin
            state_in = status.at_root ? S_POST : S_UP_CMP;
         end
         S_UP_CMP: begin
            state_in = status.up_less ? S_UP_CHECK : S_POST;
         end
         S_DN_LOAD: begin
            state_in = status.one_left ? S_POST : S_DN_RD;
         end
         S_DN_RD: begin
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            state_in = status.dn_stop ? S_POST : S_DN_RD;
         end
         S_POST: begin
            if (!status.rsp_busy) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.rd_kind = RD_NONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == ACT_ENQUEUE) begin
                  if (status.full) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = RSP_DROPPED;
                  end else begin
                     cmd.load_in = 1'b1;
                  end
               end else begin
                  if (status.empty) begin
                     cmd.res_set  = 1'b1;
                     cmd.res_code = RSP_EMPTY;
                  end else begin
                     cmd.rd_kind = RD_ROOT_LAST;
                  end
               end
            end
         end
         S_UP_CHECK: begin
            if (status.at_root) begin
               cmd.write_cur = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.res_set   = 1'b1;
               cmd.res_code  = RSP_ENQUEUED;
            end else begin
               cmd.rd_kind = RD_PARENT;
            end
         end
         S_UP_CMP: begin
            if (status.up_less) begin
               cmd.up_move = 1'b1;
            end else begin
               cmd.write_cur = 1'b1;
               cmd.count_inc = 1'b1;
               cmd.res_set   = 1'b1;
               cmd.res_code  = RSP_ENQUEUED;
            end
         end
         S_DN_LOAD: begin
            cmd.dn_load = 1'b1;
         end
         S_DN_RD: begin
            cmd.rd_kind = RD_CHILDREN;
         end
         S_DN_CMP: begin
            if (status.dn_stop) begin
               cmd.write_cur = 1'b1;
            end else begin
               cmd.dn_move = 1'b1;
            end
         end
         S_POST: begin
            cmd.post = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[rtl/bmhq_dpath.sv]
// ----------------------------------------------------------------------------
// Ready-queue min-heap datapath
// Heap memory, moving-entry register, hole index, count, config and output.
// ----------------------------------------------------------------------------
module bmhq_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  bmhq_pkg::req_type                req_data,
   input  logic                             csr_we,
   input  logic [bmhq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmhq_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  bmhq_pkg::cmd_type                cmd,
   output bmhq_pkg::status_type             status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bmhq_pkg::rsp_type                rsp_data
);
   import bmhq_pkg::*;

   entry_type             mem [CAPACITY];
   entry_type             rdata_a_ff, rdata_b_ff;
   entry_type             cur_ff, cur_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  key_mode_ff;
   logic [15:0]           quantum_ff;
   rsp_type               stg_ff, stg_in;
   rsp_type               rsp_data_ff;
   logic                  rsp_valid_ff;

   logic [ADDR_W-1:0]     addr_a, addr_b, parent, pos_m1;
   logic [CNT_W-1:0]      cnt_m1;
   logic [CHILD_W-1:0]    lc_w, rc_w;
   logic                  lc_ok, rc_ok, take_left, take_right;
   logic [KEY_W-1:0]      key_cur, key_a, key_b, key_best;
   logic                  wr_en;
   entry_type             wr_data;

   assign pos_m1 = pos_ff - ADDR_W'(1);
   assign parent = pos_m1 >> 1;
   assign cnt_m1 = count_ff - CNT_W'(1);
   assign lc_w   = CHILD_W'({pos_ff, 1'b1});
   assign rc_w   = lc_w + CHILD_W'(1);
   assign lc_ok  = lc_w < CHILD_W'(count_ff);
   assign rc_ok  = rc_w < CHILD_W'(count_ff);

   assign key_cur = key_of(cur_ff, key_mode_ff);
   assign key_a   = key_of(rdata_a_ff, key_mode_ff);
   assign key_b   = key_of(rdata_b_ff, key_mode_ff);

   // left child first; right replaces only when strictly smaller
   assign take_left  = lc_ok && (key_a < key_cur);
   assign key_best   = take_left ? key_a : key_cur;
   assign take_right = rc_ok && (key_b < key_best);

   always_comb begin
      status.full     = count_ff == CNT_W'(CAPACITY);
      status.empty    = count_ff == '0;
      status.one_left = count_ff == CNT_W'(1);
      status.at_root  = pos_ff == '0;
      status.up_less  = key_cur < key_a;
      status.dn_stop  = !take_left && !take_right;
      status.rsp_busy = rsp_valid_ff && !rsp_ready;
   end

   // read address select
   always_comb begin
      addr_a = '0;
      addr_b = '0;
      case (cmd.rd_kind)
         RD_PARENT: begin
            addr_a = parent;
         end
         RD_ROOT_LAST: begin
            addr_a = '0;
            addr_b = cnt_m1[ADDR_W-1:0];
         end
         RD_CHILDREN: begin
            addr_a = lc_w[ADDR_W-1:0];
            addr_b = rc_w[ADDR_W-1:0];
         end
         default: begin
            addr_a = '0;
         end
      endcase
   end

   assign wr_en   = cmd.write_cur || cmd.up_move || cmd.dn_move;
   assign wr_data = cmd.write_cur ? cur_ff :
                    (cmd.dn_move && take_right) ? rdata_b_ff : rdata_a_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[pos_ff] <= wr_data;
      end
      rdata_a_ff <= mem[addr_a];
      rdata_b_ff <= mem[addr_b];
   end

   always_comb begin
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      stg_in   = stg_ff;
      if (cmd.load_in) begin
         cur_in.tag   = req_data.entry_tag;
         cur_in.prio  = req_data.entry_priority;
         cur_in.burst = req_data.entry_burst;
         pos_in       = count_ff[ADDR_W-1:0];
      end
      if (cmd.up_move) begin
         pos_in = parent;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.dn_load) begin
         cur_in              = rdata_b_ff;
         pos_in              = '0;
         count_in            = cnt_m1;
         stg_in.status       = RSP_DEQUEUED;
         stg_in.out_tag      = rdata_a_ff.tag;
         stg_in.out_priority = rdata_a_ff.prio;
         stg_in.out_burst    = rdata_a_ff.burst;
         stg_in.out_quantum  = quantum_ff;
      end
      if (cmd.dn_move) begin
         pos_in = take_right ? rc_w[ADDR_W-1:0] : lc_w[ADDR_W-1:0];
      end
      if (cmd.res_set) begin
         stg_in        = '0;
         stg_in.status = cmd.res_code;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      pos_ff <= pos_in;
      stg_ff <= stg_in;
      if (cmd.post) begin
         rsp_data_ff <= stg_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         key_mode_ff  <= 1'b1;
         quantum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_MODE:     key_mode_ff <= csr_wdata[0];
               CSR_TIME_QUANTUM: quantum_ff  <= csr_wdata;
               default:          key_mode_ff <= key_mode_ff;
            endcase
         end
         if (cmd.post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/binary_min_heap_ready_queue_core.sv]
// An enqueue climbs k levels toward the root (k = 0..6) and a dequeue descends d levels
// (d = 0..5), or none when it takes the last entry; a full or empty request needs no sift.
// Requests: one in flight; no new request is taken until the response is posted, and an
// unread response in the output register holds the core before it can post.
// Reset (synchronous, active high) empties the queue, sets key_mode to priority
// and time_quantum to zero; heap memory is not cleared.
// ----------------------------------------------------------------------------
// Ready-queue binary min-heap core
// Priority queue of process entries keyed by priority or burst length.
// ----------------------------------------------------------------------------
module binary_min_heap_ready_queue_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bmhq_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bmhq_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [bmhq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bmhq_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bmhq_pkg::*;

   // controller <-> datapath
   cmd_type    cmd;
   status_type status;

   // Controller: accepts one request in idle, then walks the heap one level at
   // a time. Sift-up keeps the new entry in a register and moves parents down
   // into the hole; sift-down does the same with the smaller child, so each
   // level needs one memory write only.
   bmhq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: heap memory with two registered read ports (parent, or both
   // children, or root plus last entry) and one write port at the hole.
   // The response register lets a new request transfer while the previous
   // response still waits for the consumer.
   bmhq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Never overwrite a response that the consumer has not taken.
   assert property (@(posedge clock) disable iff (reset)
      cmd.post |-> !(rsp_valid && !rsp_ready))
      else $error("response posted over a pending response");

   // Single write port: at most one write source per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.write_cur, cmd.up_move, cmd.dn_move}))
      else $error("conflicting heap memory writes");

   // An enqueue that arrives when full is reported as dropped right away.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_ENQUEUE && status.full)
      |-> (cmd.res_set && cmd.res_code == RSP_DROPPED && !cmd.load_in))
      else $error("enqueue on full heap not dropped");

   // A dequeue transfer on an empty heap never leads to a sift-down load of the root.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == ACT_DEQUEUE && status.empty)
      |=> !cmd.dn_load)
      else $error("dequeue on empty heap touched the heap");

endmodule

[sim/binary_min_heap_ready_queue_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ready-queue min-heap core testbench
// Drives enqueue and dequeue requests through the valid/ready channels and
// checks every response against a heap predictor inside the bench. The run
// switches key mode and time quantum between phases and covers full, empty,
// ties and long response back-pressure.
// ----------------------------------------------------------------------------
module binary_min_heap_ready_queue_core_tb;
   import bmhq_pkg::*;

   localparam int PHASE_ITEMS     = 210;
   localparam int PHASE_COUNT     = 8;
   localparam int IDLE_PERCENT    = 28;
   localparam int REQ_QUIET_LO    = 600;
   localparam int REQ_QUIET_HI    = 900;
   localparam int RSP_QUIET_LO    = 620;
   localparam int RSP_QUIET_HI    = 920;
   localparam int HOLD_AT_RSP     = 1050;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 24;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int REPORT_LIMIT    = 10;

   logic                    clock;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   binary_min_heap_ready_queue_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Heap predictor state: its own copy of the store, fill level and registers.
   entry_type     heap_model [CAPACITY];
   int            held_count      = 0;
   logic          order_by_prio   = 1'b1;
   logic [15:0]   quantum_model   = '0;

   req_type       pending_req_q[$];
   rsp_type       expected_rsp_q[$];

   int            gen_level       = 0;
   int            sent_count      = 0;
   int            rsp_count       = 0;
   int            hold_left       = 0;
   int            mismatch_count  = 0;
   int            cycle_count     = 0;
   int            settings_done   = 0;
   int            stored_seen     = 0;
   int            dropped_seen    = 0;
   int            served_seen     = 0;
   int            refused_seen    = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Key of an entry under the current ordering; priority is zero-extended.
   function automatic logic [15:0] rank_of(entry_type e);
      return order_by_prio ? {8'h00, e.prio} : e.burst;
   endfunction

   function automatic void swap_slots(int a, int b);
      entry_type t;
      t             = heap_model[a];
      heap_model[a] = heap_model[b];
      heap_model[b] = t;
   endfunction

   // Apply one request to the heap copy and return the response it must cause.
   function automatic rsp_type predict_outcome(req_type r);
      rsp_type   res;
      int        pos;
      int        parent;
      int        lc;
      int        rc;
      int        best;
      logic      moving;
      res = '0;
      if (r.action == ACT_ENQUEUE) begin
         if (held_count >= CAPACITY) begin
            res.status = RSP_DROPPED;
         end else begin
            heap_model[held_count].tag   = r.entry_tag;
            heap_model[held_count].prio  = r.entry_priority;
            heap_model[held_count].burst = r.entry_burst;
            // Climb only while strictly smaller than the parent.
            pos    = held_count;
            moving = 1'b1;
            while (moving && pos > 0) begin
               parent = (pos - 1) / 2;
               if (rank_of(heap_model[pos]) < rank_of(heap_model[parent])) begin
                  swap_slots(pos, parent);
                  pos = parent;
               end else begin
                  moving = 1'b0;
               end
            end
            held_count++;
            res.status = RSP_ENQUEUED;
         end
      end else if (held_count == 0) begin
         res.status = RSP_EMPTY;
      end else begin
         res.status       = RSP_DEQUEUED;
         res.out_tag      = heap_model[0].tag;
         res.out_priority = heap_model[0].prio;
         res.out_burst    = heap_model[0].burst;
         res.out_quantum  = quantum_model;
         held_count--;
         heap_model[0] = heap_model[held_count];
         // Sink: left child first, right child only if strictly smaller.
         pos    = 0;
         moving = 1'b1;
         while (moving) begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            best = pos;
            if (lc < held_count && rank_of(heap_model[lc]) < rank_of(heap_model[best]))
               best = lc;
            if (rc < held_count && rank_of(heap_model[rc]) < rank_of(heap_model[best]))
               best = rc;
            if (best == pos) begin
               moving = 1'b0;
            end else begin
               swap_slots(pos, best);
               pos = best;
            end
         end
      end
      return res;
   endfunction

   // Field value: mostly random, sometimes an extreme, tiny range when ties are wanted.
   function automatic logic [15:0] pick_value(bit want_tie, logic [15:0] top);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (want_tie)
         return 16'($urandom_range(0, 3));
      if (roll == 0)
         return 16'h0000;
      if (roll == 1)
         return top;
      return 16'($urandom) & top;
   endfunction

   // Append one request and track the fill level it leaves behind.
   task automatic queue_item(logic act, logic [15:0] tag, logic [7:0] prio,
                             logic [15:0] burst);
      pending_req_q.push_back({act, tag, prio, burst});
      if (act == ACT_ENQUEUE && gen_level < CAPACITY)
         gen_level++;
      else if (act == ACT_DEQUEUE && gen_level > 0)
         gen_level--;
   endtask

   // Return at a falling edge once every request has been transferred and answered.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_KEY_MODE)
         order_by_prio = value[0];
      else if (idx == CSR_TIME_QUANTUM)
         quantum_model = value;
   endtask

   // Request driver: predict on every transfer, then offer the next item or idle.
   always @(posedge clock) begin : req_driver
      logic     valid_next;
      req_type  data_next;
      logic     quiet;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         valid_next = req_valid;
         data_next  = req_data;
         quiet      = (sent_count >= REQ_QUIET_LO && sent_count < REQ_QUIET_HI);
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(predict_outcome(req_data));
            sent_count++;
            valid_next = 1'b0;
         end
         // Hold valid and payload until the transfer; only reload once it is gone.
         if (!valid_next && pending_req_q.size() != 0 &&
             (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            data_next  = pending_req_q.pop_front();
            valid_next = 1'b1;
         end
         req_valid <= valid_next;
         req_data  <= data_next;
      end
   end

   // Response monitor: compare each transfer with the oldest prediction, drive ready.
   always @(posedge clock) begin : rsp_monitor
      rsp_type  exp_rsp;
      logic     ready_next;
      logic     bad;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            case (rsp_data.status)
               RSP_ENQUEUED: stored_seen++;
               RSP_DROPPED:  dropped_seen++;
               RSP_DEQUEUED: served_seen++;
               default:      refused_seen++;
            endcase
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t unexpected response %h with nothing outstanding",
                           $realtime, rsp_data);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               bad = (rsp_data.status       !== exp_rsp.status)       ||
                     (rsp_data.out_tag      !== exp_rsp.out_tag)      ||
                     (rsp_data.out_priority !== exp_rsp.out_priority) ||
                     (rsp_data.out_burst    !== exp_rsp.out_burst)    ||
                     (rsp_data.out_quantum  !== exp_rsp.out_quantum);
               if (bad) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t response %0d: status %h/%h tag %h/%h prio %h/%h burst %h/%h quantum %h/%h (exp/act)",
                              $realtime, rsp_count,
                              exp_rsp.status, rsp_data.status,
                              exp_rsp.out_tag, rsp_data.out_tag,
                              exp_rsp.out_priority, rsp_data.out_priority,
                              exp_rsp.out_burst, rsp_data.out_burst,
                              exp_rsp.out_quantum, rsp_data.out_quantum);
               end
            end
            // Start the long back-pressure window mid-phase so the input stalls.
            if (rsp_count == HOLD_AT_RSP)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (rsp_count >= RSP_QUIET_LO && rsp_count < RSP_QUIET_HI) begin
            ready_next = 1'b1;
         end else begin
            ready_next = ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog: end the run if the traffic never drains.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("binary_min_heap_ready_queue_core_tb: FAIL");
      $finish;
   end

   initial begin : stimulus
      logic          mode_plan    [PHASE_COUNT];
      logic [15:0]   quantum_plan [PHASE_COUNT];
      int            ph;
      int            k;
      int            kind;
      int            run_len;
      logic          act;
      bit            want_tie;

      mode_plan    = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      quantum_plan = '{16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom),
                       16'hFFFF, 16'h0001, 16'($urandom), 16'h0000};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part under reset defaults: priority order, zero quantum.
      queue_item(ACT_DEQUEUE, 16'h0000, 8'h00, 16'h0000);   // empty queue
      queue_item(ACT_ENQUEUE, 16'hFFFF, 8'hFF, 16'h0000);
      queue_item(ACT_ENQUEUE, 16'h0000, 8'h00, 16'hFFFF);
      queue_item(ACT_ENQUEUE, 16'h1234, 8'h80, 16'h8000);
      queue_item(ACT_ENQUEUE, 16'h0005, 8'h80, 16'h0001);   // equal priorities
      queue_item(ACT_ENQUEUE, 16'h0006, 8'h80, 16'h0002);
      queue_item(ACT_ENQUEUE, 16'h0007, 8'h01, 16'h0003);
      repeat (6) queue_item(ACT_DEQUEUE, 16'h0000, 8'h00, 16'h0000);
      queue_item(ACT_DEQUEUE, 16'h0000, 8'h00, 16'h0000);   // empty again
      queue_item(ACT_DEQUEUE, 16'hFFFF, 8'hFF, 16'hFFFF);   // ignored payload bits
      // Leave ties in the heap so the next key-mode switch sees held entries.
      for (k = 0; k < 5; k++)
         queue_item(ACT_ENQUEUE, 16'(16'hA000 + k), 8'h07, 16'(16'h0040 - k));

      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_idle();
         write_csr(CSR_KEY_MODE, CSR_DATA_W'(mode_plan[ph]));
         write_csr(CSR_TIME_QUANTUM, quantum_plan[ph]);
         settings_done++;
         @(negedge clock);
         gen_level = held_count;
         // Build the phase from runs: fill past full, drain past empty, mixes, ties.
         while (pending_req_q.size() < PHASE_ITEMS) begin
            kind     = $urandom_range(0, 4);
            want_tie = (kind == 3);
            case (kind)
               0:       run_len = CAPACITY - gen_level + $urandom_range(0, 3);
               1:       run_len = gen_level + $urandom_range(1, 2);
               3:       run_len = $urandom_range(8, 24);
               default: run_len = $urandom_range(8, 40);
            endcase
            for (k = 0; k < run_len && pending_req_q.size() < PHASE_ITEMS; k++) begin
               case (kind)
                  0:       act = ACT_ENQUEUE;
                  1:       act = ACT_DEQUEUE;
                  2:       act = $urandom_range(0, 1) ? ACT_DEQUEUE : ACT_ENQUEUE;
                  3:       act = ($urandom_range(0, 3) == 0) ? ACT_DEQUEUE : ACT_ENQUEUE;
                  default: act = ($urandom_range(0, 9) < 3) ? ACT_DEQUEUE : ACT_ENQUEUE;
               endcase
               queue_item(act, 16'($urandom), 8'(pick_value(want_tie, 16'h00FF)),
                          pick_value(want_tie, 16'hFFFF));
            end
         end
      end

      // Drain, then allow the worst-case sift latency for any stray response.
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests over %0d register settings plus reset defaults",
               sent_count, settings_done);
      $display("Responses: %0d stored, %0d dropped at full, %0d served, %0d empty",
               stored_seen, dropped_seen, served_seen, refused_seen);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("binary_min_heap_ready_queue_core_tb: PASS");
      end else begin
         $display("%0d bad responses, %0d still outstanding",
                  mismatch_count, expected_rsp_q.size());
         $display("binary_min_heap_ready_queue_core_tb: FAIL");
      end
      $finish;
   end

endmodule
